FILE: sv/mfb_pkg.sv
package mfb_pkg;

    typedef enum logic [1:0] {
        ACT_POINT = 2'd0,
        ACT_START = 2'd1,
        ACT_BYTE  = 2'd2,
        ACT_READ  = 2'd3
    } mfb_action_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RD,
        S_WR,
        S_FETCH,
        S_RESP
    } mfb_state_t;

    typedef struct packed {
        mfb_action_t action;
        logic [7:0]  x_coord;
        logic [7:0]  y_coord;
        logic        pixel_value;
        logic        blit_order;
        logic [7:0]  blit_width;
        logic [6:0]  blit_height;
        logic [7:0]  data_byte;
    } mfb_cmd_t;

    typedef struct packed {
        logic [7:0] read_data;
    } mfb_rsp_t;

    localparam logic [7:0] TOP_BIT_MASK = 8'h80;
    localparam logic [7:0] STRIP_STEP   = 8'd8;

endpackage

FILE: sv/mfb_cmd_if.sv
interface mfb_cmd_if;
    import mfb_pkg::*;

    logic     valid;
    logic     ready;
    mfb_cmd_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/mfb_rsp_if.sv
interface mfb_rsp_if;
    import mfb_pkg::*;

    logic     valid;
    logic     ready;
    mfb_rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/mfb_ram.sv
module mfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

FILE: sv/mono_framebuffer_blitter.sv
// Monochrome page frame buffer, COLUMNS x (8*PAGES) pixels, stored as one byte per
// (column, page) in a single-port-write, registered-read RAM; pixel row y sits in
// page PAGES-1-y/8 at bit 7-y%8. After reset the block sweeps the RAM to zero, one
// byte per cycle over all COLUMNS*PAGES entries, with cmd.ready low.
// Every pixel goes through one shared read-modify-write unit: a RAM read state then
// a write state. Steps per item, from acceptance back to ready:
//   draw point      idle, read, write
//   start blit      registers latched at acceptance
//   blit byte       a read and a write per pixel position stepped, off-panel ones
//                   included (1..8 positions)
//   read byte       idle, fetch, respond, plus any wait for the result register to drain
// A read result sits in an output register; rsp.valid stays until taken.
module mono_framebuffer_blitter #(
    parameter int COLUMNS = 128,
    parameter int PAGES   = 8
) (
    input  logic      clk,
    input  logic      rst_n,
    mfb_cmd_if.sink   cmd,
    mfb_rsp_if.source rsp
);
    import mfb_pkg::*;

    localparam int DEPTH = COLUMNS * PAGES;
    localparam int AW    = $clog2(DEPTH);
    localparam int ROWS  = 8 * PAGES;

    mfb_state_t  state_reg, state_next;
    mfb_action_t act_reg, act_next;

    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;

    // latched item fields
    logic [7:0] lat_x_reg, lat_x_next;
    logic [7:0] lat_y_reg, lat_y_next;
    logic       lat_val_reg, lat_val_next;
    logic [7:0] data_reg, data_next;
    logic [2:0] bit_reg, bit_next;

    // blit context
    logic [7:0] cur_x_reg, cur_x_next;
    logic [7:0] cur_y_reg, cur_y_next;
    logic [7:0] org_x_reg, org_x_next;
    logic [7:0] org_y_reg, org_y_next;
    logic [7:0] strip_reg, strip_next;
    logic       set_val_reg, set_val_next;
    logic       set_order_reg, set_order_next;
    logic [7:0] set_width_reg, set_width_next;
    logic [6:0] set_height_reg, set_height_next;

    // result register
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_data_reg, out_data_next;

    // RAM port
    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]    ram_wdata, ram_rdata;

    // shared pixel unit
    logic [7:0]    pix_x, pix_y;
    logic          pix_on, pix_in_range;
    logic [4:0]    pix_page;
    logic [AW-1:0] pix_addr;
    logic [7:0]    pix_mask;

    // byte read addressing
    logic          rd_in_range;
    logic [AW-1:0] rd_addr;

    // cursor stepping
    logic [7:0] cx1, cy1, strip_add;
    logic       col_hit, strip_hit, last_bit, byte_done;

    mfb_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // pixel address / mask, shared by points and blits
    always_comb
    begin
        pix_x        = (act_reg == ACT_POINT) ? lat_x_reg : cur_x_reg;
        pix_y        = (act_reg == ACT_POINT) ? lat_y_reg : cur_y_reg;
        pix_on       = (act_reg == ACT_POINT) ? lat_val_reg : ~(data_reg[7] ^ set_val_reg);
        pix_in_range = (9'(pix_x) < 9'(COLUMNS)) && (9'(pix_y) < 9'(ROWS));
        pix_page     = 5'(PAGES - 1) - pix_y[7:3];
        pix_addr     = AW'(32'(pix_x) * PAGES + 32'(pix_page));
        pix_mask     = TOP_BIT_MASK >> pix_y[2:0];
        rd_in_range  = (9'(lat_x_reg) < 9'(COLUMNS)) && (9'(lat_y_reg) < 9'(PAGES));
        rd_addr      = AW'(32'(lat_x_reg) * PAGES + 32'(lat_y_reg));
    end

    // run / strip end detection on 8-bit differences from the origin
    always_comb
    begin
        cx1       = cur_x_reg + 8'd1;
        cy1       = cur_y_reg + 8'd1;
        col_hit   = (8'(cy1 - org_y_reg) == {1'b0, set_height_reg});
        strip_hit = (8'(cx1 - org_x_reg) == set_width_reg);
        last_bit  = (bit_reg == 3'd7);
        byte_done = set_order_reg ? (strip_hit || last_bit) : (col_hit || last_bit);
        strip_add = strip_reg + STRIP_STEP;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_cnt_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    case (cmd.data.action)
                        ACT_POINT: state_next = S_RD;
                        ACT_BYTE:  state_next = S_RD;
                        ACT_READ:  state_next = S_FETCH;
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_RD:    state_next = S_WR;
            S_WR:
            begin
                if (act_reg == ACT_BYTE && !byte_done)
                begin
                    state_next = S_RD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_FETCH: state_next = S_RESP;
            S_RESP:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        act_next        = act_reg;
        clr_cnt_next    = clr_cnt_reg;
        lat_x_next      = lat_x_reg;
        lat_y_next      = lat_y_reg;
        lat_val_next    = lat_val_reg;
        data_next       = data_reg;
        bit_next        = bit_reg;
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        org_x_next      = org_x_reg;
        org_y_next      = org_y_reg;
        strip_next      = strip_reg;
        set_val_next    = set_val_reg;
        set_order_next  = set_order_reg;
        set_width_next  = set_width_reg;
        set_height_next = set_height_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_data_next   = out_data_reg;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        ram_waddr       = pix_addr;
        ram_raddr       = pix_addr;
        ram_wdata       = pix_on ? (ram_rdata | pix_mask) : (ram_rdata & ~pix_mask);

        case (state_reg)
            S_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                ram_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + AW'(1);
            end
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    act_next     = cmd.data.action;
                    lat_x_next   = cmd.data.x_coord;
                    lat_y_next   = cmd.data.y_coord;
                    lat_val_next = cmd.data.pixel_value;
                    data_next    = cmd.data.data_byte;
                    bit_next     = '0;
                    if (cmd.data.action == ACT_START)
                    begin
                        org_x_next      = cmd.data.x_coord;
                        org_y_next      = cmd.data.y_coord;
                        cur_x_next      = cmd.data.x_coord;
                        cur_y_next      = cmd.data.y_coord;
                        strip_next      = '0;
                        set_val_next    = cmd.data.pixel_value;
                        set_order_next  = cmd.data.blit_order;
                        set_width_next  = cmd.data.blit_width;
                        set_height_next = cmd.data.blit_height;
                    end
                end
            end
            S_RD:
            begin
                ram_re = pix_in_range;
            end
            S_WR:
            begin
                ram_we = pix_in_range;
                if (act_reg == ACT_BYTE)
                begin
                    bit_next  = byte_done ? 3'd0 : bit_reg + 3'd1;
                    data_next = data_reg << 1;
                    if (!set_order_reg)
                    begin
                        // column runs: step down, wrap to next column at run end
                        if (col_hit)
                        begin
                            cur_y_next = org_y_reg;
                            cur_x_next = cx1;
                        end
                        else
                        begin
                            cur_y_next = cy1;
                        end
                    end
                    else if (!byte_done)
                    begin
                        cur_x_next = cx1;
                    end
                    else
                    begin
                        // strip row finished: next row, maybe next strip
                        if (col_hit)
                        begin
                            strip_next = strip_add;
                            cur_y_next = org_y_reg;
                            cur_x_next = org_x_reg + strip_add;
                        end
                        else
                        begin
                            cur_y_next = cy1;
                            cur_x_next = org_x_reg + strip_reg;
                        end
                    end
                end
            end
            S_FETCH:
            begin
                ram_re    = rd_in_range;
                ram_raddr = rd_addr;
            end
            S_RESP:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = rd_in_range ? ram_rdata : '0;
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg && !rsp.ready;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            act_reg        <= ACT_POINT;
            clr_cnt_reg    <= '0;
            bit_reg        <= '0;
            cur_x_reg      <= '0;
            cur_y_reg      <= '0;
            org_x_reg      <= '0;
            org_y_reg      <= '0;
            strip_reg      <= '0;
            set_val_reg    <= 1'b0;
            set_order_reg  <= 1'b0;
            set_width_reg  <= '0;
            set_height_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            act_reg        <= act_next;
            clr_cnt_reg    <= clr_cnt_next;
            bit_reg        <= bit_next;
            cur_x_reg      <= cur_x_next;
            cur_y_reg      <= cur_y_next;
            org_x_reg      <= org_x_next;
            org_y_reg      <= org_y_next;
            strip_reg      <= strip_next;
            set_val_reg    <= set_val_next;
            set_order_reg  <= set_order_next;
            set_width_reg  <= set_width_next;
            set_height_reg <= set_height_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        lat_x_reg    <= lat_x_next;
        lat_y_reg    <= lat_y_next;
        lat_val_reg  <= lat_val_next;
        data_reg     <= data_next;
        out_data_reg <= out_data_next;
    end

    assign cmd.ready          = (state_reg == S_IDLE);
    assign rsp.valid          = out_valid_reg;
    assign rsp.data.read_data = out_data_reg;

    // a result only appears right after a buffer read completes
    a_rsp_from_read: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_RESP))
        else $error("result raised without a buffer read");

    // the buffer is never written while items are being accepted
    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ready |-> !ram_we)
        else $error("RAM write while idle");

    // a blit byte never leaves a partial bit count behind
    a_bit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WR && state_next == S_IDLE) |=> bit_reg == 3'd0)
        else $error("bit counter not rewound at end of item");

    // clearing write addresses step by one each cycle
    a_clear_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR && $past(state_reg == S_CLEAR) && $past(rst_n))
        |-> clr_cnt_reg == $past(clr_cnt_reg) + AW'(1))
        else $error("clear sweep skipped an entry");
endmodule

FILE: verif/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mfb_pkg::*;

    // Frame buffer geometry, passed down to the block
    localparam int COLS     = 128;
    localparam int PAGES    = 8;
    localparam int FB_BYTES = COLS * PAGES;

    // Watchdog: the block clears its RAM for FB_BYTES entries after reset, then
    // ~800 items plus sender gaps and receiver stalls must complete well within
    // the limit.
    localparam int CYCLE_LIMIT = 400000;

    // Cycles to wait after the last read result, longer than the slowest item
    localparam int DRAIN_CYCLES = 40;

    logic clk = 1'b0;
    logic rst_n;

    mfb_cmd_if cmd_ch ();
    mfb_rsp_if rsp_ch ();

    mono_framebuffer_blitter #(
        .COLUMNS(COLS),
        .PAGES  (PAGES)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (cmd_ch),
        .rsp  (rsp_ch)
    );

    // Shadow copy of the frame buffer and the blit cursor. Every accepted item
    // is applied here; each read item queues the byte the block must return.
    class frame_scoreboard;
        logic [7:0] frame [FB_BYTES];
        logic [7:0] cur_x, cur_y, org_x, org_y, strip_off;
        logic       draw_val, strip_mode;
        logic [7:0] run_width;
        logic [6:0] run_height;
        logic [7:0] expected_reads [$];
        int         fail_count;

        // Matches the block's state after reset: buffer clear, blit settings zero
        function new();
            foreach (frame[i])
                frame[i] = '0;
            cur_x      = '0;
            cur_y      = '0;
            org_x      = '0;
            org_y      = '0;
            strip_off  = '0;
            draw_val   = 1'b0;
            strip_mode = 1'b0;
            run_width  = '0;
            run_height = '0;
            fail_count = 0;
        endfunction

        // Row y lives in page PAGES-1-y/8, bit 7-y%8; off-panel pixels drop
        function void plot(logic [7:0] x, logic [7:0] y, logic on);
            int         idx;
            logic [7:0] mask;
            if (x >= COLS || y >= 8 * PAGES)
                return;
            idx  = int'(x) * PAGES + (PAGES - 1 - int'(y) / 8);
            mask = TOP_BIT_MASK >> y[2:0];
            if (on)
                frame[idx] = frame[idx] | mask;
            else
                frame[idx] = frame[idx] & ~mask;
        endfunction

        // One bitmap byte, MSB first; zero bits draw the inverse value.
        // Cursor sums wrap at 8 bits, so a zero size ends only on wraparound.
        function void draw_byte(logic [7:0] bits);
            int         b;
            logic [7:0] diff;
            if (!strip_mode) begin
                for (b = 7; b >= 0; b--) begin
                    plot(cur_x, cur_y, bits[b] ? draw_val : !draw_val);
                    cur_y = cur_y + 8'd1;
                    diff  = cur_y - org_y;
                    if (diff == {1'b0, run_height}) begin
                        cur_y = org_y;
                        cur_x = cur_x + 8'd1;
                        break;
                    end
                end
            end
            else begin
                for (b = 7; b >= 0; b--) begin
                    plot(cur_x, cur_y, bits[b] ? draw_val : !draw_val);
                    cur_x = cur_x + 8'd1;
                    diff  = cur_x - org_x;
                    if (diff == run_width)
                        break;
                end
                cur_y = cur_y + 8'd1;
                diff  = cur_y - org_y;
                if (diff == {1'b0, run_height}) begin
                    strip_off = strip_off + STRIP_STEP;
                    cur_y     = org_y;
                end
                cur_x = org_x + strip_off;
            end
        endfunction

        function void note_cmd(mfb_cmd_t c);
            case (c.action)
                ACT_POINT: plot(c.x_coord, c.y_coord, c.pixel_value);
                ACT_START:
                begin
                    org_x      = c.x_coord;
                    org_y      = c.y_coord;
                    cur_x      = c.x_coord;
                    cur_y      = c.y_coord;
                    strip_off  = '0;
                    draw_val   = c.pixel_value;
                    strip_mode = c.blit_order;
                    run_width  = c.blit_width;
                    run_height = c.blit_height;
                end
                ACT_BYTE: draw_byte(c.data_byte);
                ACT_READ:
                begin
                    // Out-of-range reads still answer, with zero
                    if (c.x_coord < COLS && c.y_coord < PAGES)
                        expected_reads.push_back(
                            frame[int'(c.x_coord) * PAGES + int'(c.y_coord)]);
                    else
                        expected_reads.push_back(8'h00);
                end
                default: ;
            endcase
        endfunction

        function void check_read(mfb_rsp_t r);
            logic [7:0] want;
            if (expected_reads.size() == 0) begin
                $error("read_data with no read pending: actual %02h", r.read_data);
                fail_count++;
                return;
            end
            want = expected_reads.pop_front();
            if (r.read_data !== want) begin
                $error("read_data mismatch: expected %02h, actual %02h", want, r.read_data);
                fail_count++;
            end
        endfunction
    endclass

    frame_scoreboard sb = new();

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int items_sent    = 0;
    int cycle_count;

    // Clock, 10 ns period
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result side: ready toggles at random per the current phase
    always @(posedge clk)
        rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

    // Both handshakes are sampled at the edge; DUT and driver updates land in
    // the NBA region, so the values read here are the ones that were accepted.
    // A result taken now always belongs to an earlier read, so check first.
    always @(posedge clk)
    begin
        if (rsp_ch.valid && rsp_ch.ready)
            sb.check_read(rsp_ch.data);
        if (cmd_ch.valid && cmd_ch.ready)
            sb.note_cmd(cmd_ch.data);
    end

    // Watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    // Fully random item; callers override the fields that matter
    function automatic mfb_cmd_t random_cmd();
        mfb_cmd_t c;
        c.action      = mfb_action_t'($urandom_range(3));
        c.x_coord     = 8'($urandom);
        c.y_coord     = 8'($urandom);
        c.pixel_value = 1'($urandom);
        c.blit_order  = 1'($urandom);
        c.blit_width  = 8'($urandom);
        c.blit_height = 7'($urandom);
        c.data_byte   = 8'($urandom);
        return c;
    endfunction

    // Valid is left high after a handshake so back-to-back items never see it
    // lowered and raised in the same step; it only drops during a gap.
    task automatic send_cmd(input mfb_cmd_t c, input bit counted);
        while ($urandom_range(99) < send_idle_pct) begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.data  <= c;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        if (counted)
            items_sent++;
    endtask

    task automatic do_point(input int x, input int y, input bit v);
        mfb_cmd_t c;
        c             = random_cmd();
        c.action      = ACT_POINT;
        c.x_coord     = 8'(x);
        c.y_coord     = 8'(y);
        c.pixel_value = v;
        send_cmd(c, 1'b1);
    endtask

    task automatic do_read(input int col, input int page);
        mfb_cmd_t c;
        c         = random_cmd();
        c.action  = ACT_READ;
        c.x_coord = 8'(col);
        c.y_coord = 8'(page);
        send_cmd(c, 1'b1);
    endtask

    task automatic do_start(input int x, input int y, input bit v, input bit order,
                            input int w, input int h);
        mfb_cmd_t c;
        c             = random_cmd();
        c.action      = ACT_START;
        c.x_coord     = 8'(x);
        c.y_coord     = 8'(y);
        c.pixel_value = v;
        c.blit_order  = order;
        c.blit_width  = 8'(w);
        c.blit_height = 7'(h);
        send_cmd(c, 1'b1);
    endtask

    task automatic do_byte(input int d);
        mfb_cmd_t c;
        c           = random_cmd();
        c.action    = ACT_BYTE;
        c.data_byte = 8'(d);
        send_cmd(c, 1'b1);
    endtask

    // Start a blit, feed it bytes, read back around the origin. Sizes are
    // mostly small; a few bursts use the full panel or raw field values
    // (zero sizes included), and some byte counts are cut short or overrun.
    task automatic blit_burst();
        int ox, oy, w, h, n_bytes, i, pick;
        bit order;
        order = 1'($urandom);
        ox    = $urandom_range(127);
        oy    = $urandom_range(63);
        w     = $urandom_range(1, 24);
        h     = $urandom_range(1, 20);
        pick  = $urandom_range(99);
        if (pick < 8) begin
            w  = 128;
            h  = 64;
            ox = $urandom_range(3);
            oy = $urandom_range(3);
        end
        else if (pick < 16) begin
            w  = $urandom_range(255);
            h  = $urandom_range(127);
            ox = $urandom_range(255);
            oy = $urandom_range(255);
        end
        if (order)
            n_bytes = h * ((w + 7) / 8);
        else
            n_bytes = ((h + 7) / 8) * $urandom_range(1, 4);
        if (n_bytes == 0 || n_bytes > 48)
            n_bytes = $urandom_range(8, 48);
        if ($urandom_range(9) == 0)
            n_bytes = $urandom_range(1, n_bytes + 8);
        do_start(ox, oy, 1'($urandom), order, w, h);
        for (i = 0; i < n_bytes; i++) begin
            do_byte($urandom_range(255));
            // Occasional read or stray point in the middle of a run
            if ($urandom_range(7) == 0)
                do_read(ox + $urandom_range(20), $urandom_range(7));
            if ($urandom_range(29) == 0)
                do_point($urandom_range(127), $urandom_range(63), 1'($urandom));
        end
        repeat ($urandom_range(2, 5))
            do_read((ox + $urandom_range(24)) % 256, $urandom_range(7));
    endtask

    // Single pixels, each read back from the byte that holds it
    task automatic point_burst();
        int px, py;
        repeat ($urandom_range(1, 4)) begin
            px = $urandom_range(135);
            py = $urandom_range(70);
            do_point(px, py, 1'($urandom));
            do_read(px, PAGES - 1 - py / 8);
        end
    endtask

    task automatic run_phase(input int n_items, input int s_pct, input int r_pct);
        int target, pick;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        target        = items_sent + n_items;
        while (items_sent < target) begin
            pick = $urandom_range(99);
            if (pick < 65)
                blit_burst();
            else if (pick < 85)
                point_burst();
            else
                // raw noise: any action, any field value; not counted
                repeat ($urandom_range(1, 6))
                    send_cmd(random_cmd(), 1'b0);
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.data  = '0;
        rsp_ch.ready = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, sender and receiver never idle
        do_read(0, 0);                      // cleared buffer
        do_point(0, 0, 1'b1);               // top-left pixel: page 7, bit 7
        do_point(127, 63, 1'b1);            // bottom-right: page 0, bit 0
        do_point(128, 0, 1'b1);             // off panel, x
        do_point(0, 64, 1'b1);              // off panel, y
        do_point(255, 255, 1'b1);
        do_read(0, 7);
        do_read(127, 0);
        do_read(128, 0);                    // read off panel returns zero
        do_read(255, 255);
        do_byte(8'hA5);                     // blit with no start: reset settings
        do_read(0, 7);
        do_point(0, 2, 1'b0);               // clear one pixel
        do_start(120, 60, 1'b1, 1'b0, 8, 5); // column runs clipped at bottom
        do_byte(8'hFF);
        do_byte(8'h01);
        do_read(121, 0);
        do_start(124, 0, 1'b0, 1'b1, 12, 2); // glyph strip clipped at right
        do_byte(8'h00);
        do_byte(8'h80);
        do_byte(8'hF0);
        do_byte(8'h0F);
        do_read(124, 7);
        do_start(0, 0, 1'b1, 1'b1, 0, 0);   // zero width and height
        do_byte(8'h5A);
        do_read(0, 7);

        // Random part in three idling phases
        run_phase(260, 26, 79);
        run_phase(260, 79, 26);
        run_phase(260, 0, 0);

        // Drop valid at the edge that took the last item
        cmd_ch.valid <= 1'b0;
        while (sb.expected_reads.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.fail_count == 0 && sb.expected_reads.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

FILE: mono_framebuffer_blitter.f
sv/mfb_pkg.sv
sv/mfb_cmd_if.sv
sv/mfb_rsp_if.sv
sv/mfb_ram.sv
sv/mono_framebuffer_blitter.sv
verif/testbench.sv
